// ----- rtl/core/smf_pkg.sv -----
// shared constants, types and helpers of the switching median filter
// no dependencies
package smf_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_RADIUS  = 7;
	localparam int BINS        = 256;
	localparam int RING_SIZE   = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
	localparam int SLOT_W      = $clog2(RING_SIZE);
	localparam int WID_W       = 12;
	localparam int HGT_W       = 13;
	localparam int RREG_W      = 3;
	localparam int THR_W       = 8;
	localparam int DATA_W      = 13;
	localparam int POS_W       = 12;
	localparam int K_W         = WID_W + HGT_W;
	localparam int RAD_W       = $clog2(MAX_RADIUS + 1);
	localparam int SIDE_W      = RAD_W + 1;
	localparam int TOT_W       = 2 * SIDE_W;
	localparam int LAG_W       = RAD_W + WID_W + 1;
	localparam int BIN_W       = $clog2(BINS);
	localparam int QUEUE_DEPTH = 2;
	localparam int PIX_W       = 24;

	localparam logic [WID_W-1:0]  RST_WIDTH  = 12'd640;
	localparam logic [HGT_W-1:0]  RST_HEIGHT = 13'd480;
	localparam logic [RREG_W-1:0] RST_RADIUS = 3'd1;
	localparam logic [THR_W-1:0]  RST_THRESH = 8'd40;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2,
		REG_THRESH = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_POS,
		ST_MUL,
		ST_DIFF,
		ST_SLOT,
		ST_LSDATA,
		ST_HINC,
		ST_SCAN,
		ST_FIN
	} back_st_t;

	typedef struct packed {
		logic [WID_W-1:0] w;
		logic [HGT_W-1:0] h;
		logic [RAD_W-1:0] r;
		logic [THR_W-1:0] thr;
	} cfg_t;

	typedef struct packed {
		logic              wr;
		logic              em;
		logic              last;
		logic [PIX_W-1:0]  rgb;
		logic [SLOT_W-1:0] wslot;
		logic [K_W-1:0]    refk;
		logic [SLOT_W-1:0] refslot;
		logic [POS_W-1:0]  oy;
		logic [POS_W-1:0]  ox;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	function automatic logic [RAD_W-1:0] eff_radius(input logic [RREG_W-1:0] r);
		logic [7:0] rr;
		rr = 8'(r);
		return (rr > 8'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(rr);
	endfunction

endpackage

// ----- rtl/core/smf_if.sv -----
// pixel stream interfaces of the switching median filter
// no dependencies
interface smf_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	modport source(output valid, func, red_in, green_in, blue_in, input ready);
	modport sink(input valid, func, red_in, green_in, blue_in, output ready);
endinterface

interface smf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       frame_end;
	modport source(output valid, red_out, green_out, blue_out, frame_end, input ready);
	modport sink(input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

// ----- rtl/core/switching_median_filter_rgb_top.sv -----
// switching median filter, rgb: top level with configuration registers
// depends on smf_pkg, smf_if, smf_front, smf_queue, smf_back
//
// pix_in carries raster-order pixels (func 0) or drain ticks (func 1);
// pix_out carries filtered pixels, frame_end on the frame's last one.
// a transfer happens when valid and ready are both high. the config
// port writes frame_width, frame_height, window_radius, replace_threshold
// at index 0..3 and restarts the frame; write it only while idle.
// output lags input by r rows and r columns; drain ticks after the
// frame flush the remaining pixels, one per tick.
// a pixel that produces no result is only written to the line store. a result
// takes a 256-bin histogram clear per channel, six sequencer steps per
// window sample (position, multiply, difference, slot, line store read,
// histogram read and increment), then a bin scan.
// a two-entry command queue lets the input side run ahead of the
// median engine; a stalled receiver holds the output register and the
// engine waits in its final step. reset clears positions and config
// to 640x480, radius 1, threshold 40; memories need no clearing.
module switching_median_filter_rgb_top (
	input  logic                       clk,
	input  logic                       arst_n,
	smf_in_if.sink                     pix_in,
	smf_out_if.source                  pix_out,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [smf_pkg::DATA_W-1:0] cfg_data
);
	logic [smf_pkg::WID_W-1:0]  width_q;
	logic [smf_pkg::HGT_W-1:0]  height_q;
	logic [smf_pkg::RREG_W-1:0] radius_q;
	logic [smf_pkg::THR_W-1:0]  thresh_q;
	smf_pkg::cfg_t              cfg;
	smf_pkg::cmd_t              push_cmd, pop_cmd;
	smf_pkg::q_stat_t           q_stat;
	logic                       push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= smf_pkg::RST_WIDTH;
			height_q <= smf_pkg::RST_HEIGHT;
			radius_q <= smf_pkg::RST_RADIUS;
			thresh_q <= smf_pkg::RST_THRESH;
		end else if (cfg_we) begin
			unique case (smf_pkg::reg_idx_t'(cfg_index))
				smf_pkg::REG_WIDTH:  width_q  <= cfg_data[smf_pkg::WID_W-1:0];
				smf_pkg::REG_HEIGHT: height_q <= cfg_data[smf_pkg::HGT_W-1:0];
				smf_pkg::REG_RADIUS: radius_q <= cfg_data[smf_pkg::RREG_W-1:0];
				smf_pkg::REG_THRESH: thresh_q <= cfg_data[smf_pkg::THR_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) cfg.w = smf_pkg::WID_W'(1);
		else if (13'(width_q) > 13'(smf_pkg::MAX_WIDTH)) cfg.w = smf_pkg::WID_W'(smf_pkg::MAX_WIDTH);
		else cfg.w = width_q;
		cfg.h   = (height_q == '0) ? smf_pkg::HGT_W'(1) : height_q;
		cfg.r   = smf_pkg::eff_radius(radius_q);
		cfg.thr = thresh_q;
	end

	smf_front u_front (
		.clk(clk), .arst_n(arst_n), .pix_in(pix_in), .cfg(cfg), .cfg_we(cfg_we),
		.q_full(q_stat.full), .q_push(push), .q_cmd(push_cmd)
	);

	smf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd),
		.pop(pop), .pop_cmd(pop_cmd), .stat(q_stat)
	);

	smf_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .q_stat(q_stat), .q_cmd(pop_cmd),
		.q_pop(pop), .pix_out(pix_out)
	);
endmodule

// ----- rtl/core/smf_ram.sv -----
// generic one write, one read port ram with registered read
// no dependencies
module smf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/smf_front.sv -----
// front end: accepts items, tracks frame positions, issues write and emit commands
// depends on smf_pkg and smf_if
module smf_front (
	input  logic           clk,
	input  logic           arst_n,
	smf_in_if.sink         pix_in,
	input  smf_pkg::cfg_t  cfg,
	input  logic           cfg_we,
	input  logic           q_full,
	output logic           q_push,
	output smf_pkg::cmd_t  q_cmd
);
	logic [smf_pkg::HGT_W-1:0]  in_row_q;
	logic [smf_pkg::POS_W-1:0]  in_col_q;
	logic [smf_pkg::K_W-1:0]    k_q, lastk_q;
	logic [smf_pkg::SLOT_W-1:0] slot_q, lastslot_q;
	logic [smf_pkg::POS_W-1:0]  orow_q, ocol_q;
	logic [smf_pkg::LAG_W-1:0]  lag;
	logic [smf_pkg::HGT_W-1:0]  hm1;
	logic acc, in_done, do_wr, do_em, last;

	assign pix_in.ready = !q_full;
	assign acc     = pix_in.valid && pix_in.ready;
	assign lag     = smf_pkg::LAG_W'(cfg.r * cfg.w) + smf_pkg::LAG_W'(cfg.r);
	assign hm1     = cfg.h - smf_pkg::HGT_W'(1);
	assign in_done = in_row_q >= cfg.h;
	assign do_wr   = acc && !in_done && !pix_in.func;
	assign do_em   = acc && (in_done || (!pix_in.func && k_q >= smf_pkg::K_W'(lag)));
	assign last    = (orow_q == hm1[smf_pkg::POS_W-1:0]) && (ocol_q == cfg.w - 12'd1);
	assign q_push  = do_wr || do_em;

	always_comb begin
		q_cmd.wr      = do_wr;
		q_cmd.em      = do_em;
		q_cmd.last    = last;
		q_cmd.rgb     = {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
		q_cmd.wslot   = slot_q;
		q_cmd.refk    = do_wr ? k_q : lastk_q;
		q_cmd.refslot = do_wr ? slot_q : lastslot_q;
		q_cmd.oy      = orow_q;
		q_cmd.ox      = ocol_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q   <= '0;
			in_col_q   <= '0;
			k_q        <= '0;
			slot_q     <= '0;
			lastk_q    <= '0;
			lastslot_q <= '0;
			orow_q     <= '0;
			ocol_q     <= '0;
		end else if (cfg_we || (do_em && last)) begin
			in_row_q <= '0;
			in_col_q <= '0;
			k_q      <= '0;
			slot_q   <= '0;
			orow_q   <= '0;
			ocol_q   <= '0;
		end else begin
			if (do_wr) begin
				lastk_q    <= k_q;
				lastslot_q <= slot_q;
				k_q        <= k_q + smf_pkg::K_W'(1);
				slot_q     <= (slot_q == smf_pkg::SLOT_W'(smf_pkg::RING_SIZE - 1)) ?
					'0 : slot_q + smf_pkg::SLOT_W'(1);
				if (in_col_q + 12'd1 >= cfg.w) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + smf_pkg::HGT_W'(1);
				end else begin
					in_col_q <= in_col_q + 12'd1;
				end
			end
			if (do_em) begin
				if (ocol_q + 12'd1 >= cfg.w) begin
					ocol_q <= '0;
					orow_q <= orow_q + 12'd1;
				end else begin
					ocol_q <= ocol_q + 12'd1;
				end
			end
		end
	end
endmodule

// ----- rtl/core/smf_queue.sv -----
// short command queue between front and back end
// depends on smf_pkg
module smf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  smf_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output smf_pkg::cmd_t     pop_cmd,
	output smf_pkg::q_stat_t  stat
);
	localparam int PW = $clog2(smf_pkg::QUEUE_DEPTH);

	smf_pkg::cmd_t mem_q [smf_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign stat.valid = cnt_q != '0;
	assign stat.full  = cnt_q == (PW+1)'(smf_pkg::QUEUE_DEPTH);
	assign pop_cmd    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(smf_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(smf_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

// ----- rtl/core/smf_back.sv -----
// back end: line store, per channel histograms, median search and output register
// depends on smf_pkg, smf_if and smf_ram
module smf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  smf_pkg::cfg_t     cfg,
	input  smf_pkg::q_stat_t  q_stat,
	input  smf_pkg::cmd_t     q_cmd,
	output logic              q_pop,
	smf_out_if.source         pix_out
);
	localparam int CW = smf_pkg::TOT_W;

	smf_pkg::back_st_t st_q, st_d;
	smf_pkg::cmd_t     cmd_q;

	logic [smf_pkg::BIN_W:0]     bin_q;
	logic signed [smf_pkg::RAD_W:0] dy_q, dx_q, r_s;
	logic [smf_pkg::POS_W-1:0]   yy_q, xx_q, yy_c, xx_c;
	logic [smf_pkg::K_W-1:0]     prod_q, d_q;
	logic [smf_pkg::PIX_W-1:0]   samp_q, centre_q, ls_rdata, ls_wdata;
	logic [smf_pkg::SLOT_W:0]    sd;
	logic [smf_pkg::SLOT_W-1:0]  slot_c, ls_waddr;
	logic                        ls_we, h_we, out_free, out_load, win_end, row_end;
	logic [2:0]                  found_q;
	logic [CW:0]                 cnt_q [3];
	logic [7:0]                  med_q [3];
	logic [7:0]                  h_raddr [3], h_waddr [3];
	logic [CW-1:0]               h_wdata [3], h_rdata [3];
	logic [smf_pkg::SIDE_W-1:0]  side;
	logic [CW-1:0]               total, half;
	logic signed [13:0]          ys, xs;
	logic [7:0]                  res [3];
	logic                        ov_q, fe_q;
	logic [7:0]                  ro_q, go_q, bo_q;

	assign r_s   = $signed({1'b0, cfg.r});
	assign side  = {cfg.r, 1'b1};
	assign total = CW'(side * side);
	assign half  = total >> 1;

	assign ys = $signed({2'b00, cmd_q.oy}) + 14'(dy_q);
	assign xs = $signed({2'b00, cmd_q.ox}) + 14'(dx_q);

	always_comb begin
		if (ys < 0) yy_c = '0;
		else if (ys >= $signed({1'b0, cfg.h})) yy_c = 12'(cfg.h - 13'd1);
		else yy_c = ys[smf_pkg::POS_W-1:0];
		if (xs < 0) xx_c = '0;
		else if (xs >= $signed({2'b00, cfg.w})) xx_c = cfg.w - 12'd1;
		else xx_c = xs[smf_pkg::POS_W-1:0];
	end

	assign sd     = {1'b0, cmd_q.refslot} - {1'b0, d_q[smf_pkg::SLOT_W-1:0]};
	assign slot_c = sd[smf_pkg::SLOT_W] ?
		smf_pkg::SLOT_W'(sd + (smf_pkg::SLOT_W+1)'(smf_pkg::RING_SIZE)) :
		sd[smf_pkg::SLOT_W-1:0];

	assign row_end  = dx_q == r_s;
	assign win_end  = row_end && (dy_q == r_s);
	assign out_free = !ov_q || pix_out.ready;

	smf_ram #(.WIDTH(smf_pkg::PIX_W), .DEPTH(smf_pkg::RING_SIZE)) u_line (
		.clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
		.raddr(slot_c), .rdata(ls_rdata)
	);

	for (genvar c = 0; c < 3; c++) begin : g_hist
		smf_ram #(.WIDTH(CW), .DEPTH(smf_pkg::BINS)) u_hist (
			.clk(clk), .we(h_we), .waddr(h_waddr[c]), .wdata(h_wdata[c]),
			.raddr(h_raddr[c]), .rdata(h_rdata[c])
		);
		assign res[c] = ((centre_q[23-8*c -: 8] > med_q[c] ?
			centre_q[23-8*c -: 8] - med_q[c] : med_q[c] - centre_q[23-8*c -: 8])
			> cfg.thr) ? med_q[c] : centre_q[23-8*c -: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= smf_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d     = st_q;
		q_pop    = 1'b0;
		ls_we    = 1'b0;
		ls_waddr = q_cmd.wslot;
		ls_wdata = q_cmd.rgb;
		h_we     = 1'b0;
		out_load = 1'b0;
		for (int c = 0; c < 3; c++) begin
			h_raddr[c] = bin_q[smf_pkg::BIN_W-1:0];
			h_waddr[c] = bin_q[smf_pkg::BIN_W-1:0];
			h_wdata[c] = '0;
		end
		unique case (st_q)
			smf_pkg::ST_IDLE: begin
				if (q_stat.valid) begin
					q_pop = 1'b1;
					ls_we = q_cmd.wr;
					if (q_cmd.em) st_d = smf_pkg::ST_CLEAR;
				end
			end
			smf_pkg::ST_CLEAR: begin
				h_we = 1'b1;
				if (bin_q == (smf_pkg::BIN_W+1)'(smf_pkg::BINS - 1)) st_d = smf_pkg::ST_POS;
			end
			smf_pkg::ST_POS:  st_d = smf_pkg::ST_MUL;
			smf_pkg::ST_MUL:  st_d = smf_pkg::ST_DIFF;
			smf_pkg::ST_DIFF: st_d = smf_pkg::ST_SLOT;
			smf_pkg::ST_SLOT: st_d = smf_pkg::ST_LSDATA;
			smf_pkg::ST_LSDATA: begin
				for (int c = 0; c < 3; c++) h_raddr[c] = ls_rdata[23-8*c -: 8];
				st_d = smf_pkg::ST_HINC;
			end
			smf_pkg::ST_HINC: begin
				h_we = 1'b1;
				for (int c = 0; c < 3; c++) begin
					h_waddr[c] = samp_q[23-8*c -: 8];
					h_wdata[c] = h_rdata[c] + CW'(1);
				end
				st_d = win_end ? smf_pkg::ST_SCAN : smf_pkg::ST_POS;
			end
			smf_pkg::ST_SCAN: begin
				if (bin_q == (smf_pkg::BIN_W+1)'(smf_pkg::BINS)) st_d = smf_pkg::ST_FIN;
			end
			smf_pkg::ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					st_d     = smf_pkg::ST_IDLE;
				end
			end
			default: st_d = smf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_cmd;
		unique case (st_q)
			smf_pkg::ST_IDLE: bin_q <= '0;
			smf_pkg::ST_CLEAR: begin
				bin_q <= bin_q + 1'b1;
				dy_q  <= -r_s;
				dx_q  <= -r_s;
			end
			smf_pkg::ST_POS: begin
				yy_q <= yy_c;
				xx_q <= xx_c;
			end
			smf_pkg::ST_MUL:  prod_q <= smf_pkg::K_W'(yy_q * cfg.w);
			smf_pkg::ST_DIFF: d_q <= cmd_q.refk - prod_q - smf_pkg::K_W'(xx_q);
			smf_pkg::ST_SLOT: ;
			smf_pkg::ST_LSDATA: begin
				samp_q <= ls_rdata;
				if (dy_q == 0 && dx_q == 0) centre_q <= ls_rdata;
			end
			smf_pkg::ST_HINC: begin
				bin_q   <= '0;
				found_q <= '0;
				for (int c = 0; c < 3; c++) cnt_q[c] <= '0;
				if (row_end) begin
					dx_q <= -r_s;
					dy_q <= dy_q + 1'b1;
				end else begin
					dx_q <= dx_q + 1'b1;
				end
			end
			smf_pkg::ST_SCAN: begin
				bin_q <= bin_q + 1'b1;
				if (bin_q != '0) begin
					for (int c = 0; c < 3; c++) begin
						if (!found_q[c]) begin
							cnt_q[c] <= cnt_q[c] + (CW+1)'(h_rdata[c]);
							if (cnt_q[c] + (CW+1)'(h_rdata[c]) > (CW+1)'(half)) begin
								found_q[c] <= 1'b1;
								med_q[c]   <= 8'(bin_q - 1'b1);
							end
						end
					end
				end
			end
			smf_pkg::ST_FIN: ;
			default: ;
		endcase
		if (out_load) begin
			ro_q <= res[0];
			go_q <= res[1];
			bo_q <= res[2];
			fe_q <= cmd_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (out_load) ov_q <= 1'b1;
		else if (pix_out.ready) ov_q <= 1'b0;
	end

	assign pix_out.valid     = ov_q;
	assign pix_out.red_out   = ro_q;
	assign pix_out.green_out = go_q;
	assign pix_out.blue_out  = bo_q;
	assign pix_out.frame_end = fe_q;

	a_median_found: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == smf_pkg::ST_FIN |-> &found_q)
		else $error("median search ended without a median");
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == smf_pkg::ST_SLOT |-> slot_c < smf_pkg::SLOT_W'(smf_pkg::RING_SIZE))
		else $error("line store slot out of range");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> pix_out.valid && (st_q == smf_pkg::ST_IDLE))
		else $error("result not presented after load");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.valid && (st_q == smf_pkg::ST_IDLE))
		else $error("queue popped outside idle");
endmodule
